[hdl/assert_macros.svh]
// Shared assertion macros: clocked on clk_i, quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define RTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expr must never be true at a clock edge out of reset
`define RTS_ASSERT_NEVER(label, expr, msg) \
  `RTS_ASSERT(label, !(expr), msg)

`endif

[hdl/rts_pkg.sv]
package rts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_CHARS  = 8;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int BOUND_W  = CNT_W + 1;
  localparam int BRANCH_W = 64;
  localparam int NUM_W    = 32;
  localparam int NAME_W   = 8 * NAME_CHARS;
  localparam int OP_W     = 2;
  localparam int SEL_W    = 2;

  localparam logic [BRANCH_W-1:0] NAME_MASK = {BRANCH_W{1'b1}} >> (BRANCH_W - NAME_W);
  localparam logic [NUM_W-1:0]    SIGN_BIAS = {1'b1, {(NUM_W - 1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_LINEAR = 2'd1,
    OP_BINARY = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_BRANCH = 2'd0,
    SEL_LOAN   = 2'd1,
    SEL_AMOUNT = 2'd2,
    SEL_NONE   = 2'd3
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [BRANCH_W-1:0] branch;
    logic [NUM_W-1:0]    loan;
    logic [NUM_W-1:0]    amount;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic clear;
    logic init;
    logic advance;
    logic mark_found;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic sel_none;
    logic empty;
    logic hit;
    logic last;
  } stat_t;

endpackage

[hdl/record_table_search_top.sv]
// Record table with search. Pulse start_i while busy_o is low to issue one
// command: load a record, clear the table, or run a linear or binary search
// on the field chosen by field_select_i. Every command gives one result:
// done_o is high for exactly one cycle with found_o and status_o valid, and
// the result cannot be held off. Load and clear pass from accept through the
// dispatch and done states back to idle. A search passes through dispatch,
// then one read and one check state per probe, then done. Each probe needs
// both states, set by the single read port of the record memory and its
// registered read data. Binary search expects the table to be sorted on the
// searched field.
module record_table_search_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  output logic                                done_o,
  input  logic [rts_pkg::OP_W-1:0]            opcode_i,
  input  logic [rts_pkg::SEL_W-1:0]           field_select_i,
  input  logic [rts_pkg::BRANCH_W-1:0]        branch_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    loan_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    amount_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    number_key_i,
  output logic                                found_o,
  output logic                                status_o
);
  import rts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  rts_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .field_select_i (field_select_i),
    .branch_value_i (branch_value_i),
    .loan_value_i   (loan_value_i),
    .amount_value_i (amount_value_i),
    .number_key_i   (number_key_i),
    .found_o        (found_o),
    .status_o       (status_o)
  );

endmodule

[hdl/rts_ctrl.sv]
module rts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rts_pkg::stat_t stat_i,
  output rts_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  import rts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    done_o  = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.op)
          OP_LOAD: begin
            cmd_o.load = 1'b1;
            state_d    = ST_DONE;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_DONE;
          end
          default: begin
            if (stat_i.sel_none || stat_i.empty) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.init = 1'b1;
              state_d    = ST_READ;
            end
          end
        endcase
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.hit) begin
          cmd_o.mark_found = 1'b1;
          state_d          = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = stat_i.last ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/rts_datapath.sv]
module rts_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rts_pkg::cmd_t                       cmd_i,
  output rts_pkg::stat_t                      stat_o,
  input  logic [rts_pkg::OP_W-1:0]            opcode_i,
  input  logic [rts_pkg::SEL_W-1:0]           field_select_i,
  input  logic [rts_pkg::BRANCH_W-1:0]        branch_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    loan_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    amount_value_i,
  input  logic signed [rts_pkg::NUM_W-1:0]    number_key_i,
  output logic                                found_o,
  output logic                                status_o
);
  import rts_pkg::*;

  rec_t                rec_mem_q [TABLE_DEPTH];
  rec_t                rd_q;

  op_e                 op_q;
  sel_e                sel_q;
  logic [BRANCH_W-1:0] key_q;
  rec_t                wr_rec_q;
  logic [CNT_W-1:0]    count_q;
  logic                found_q;
  logic                status_q;
  logic signed [BOUND_W-1:0] lo_q, lo_d;
  logic signed [BOUND_W-1:0] hi_q, hi_d;

  logic signed [BOUND_W:0]   bound_sum;
  logic signed [BOUND_W-1:0] mid;
  logic [IDX_W-1:0]          rd_addr;
  logic [BRANCH_W-1:0]       probe_val;
  logic                      full;
  logic                      key_lt;

  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign bound_sum = lo_q + hi_q;
  // bounds are non-negative while probing, so the shift is the midpoint
  assign mid       = $signed(bound_sum[BOUND_W:1]);
  assign rd_addr   = (op_q == OP_LINEAR) ? lo_q[IDX_W-1:0] : mid[IDX_W-1:0];

  // numbers are biased so that unsigned order is signed order
  always_comb begin
    case (sel_q)
      SEL_BRANCH: probe_val = rd_q.branch;
      SEL_LOAN:   probe_val = {{(BRANCH_W - NUM_W){1'b0}}, rd_q.loan ^ SIGN_BIAS};
      SEL_AMOUNT: probe_val = {{(BRANCH_W - NUM_W){1'b0}}, rd_q.amount ^ SIGN_BIAS};
      default:    probe_val = '0;
    endcase
  end

  assign key_lt = (key_q < probe_val);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (op_q == OP_LINEAR) begin
      lo_d = lo_q + BOUND_W'(1);
    end else if (key_lt) begin
      hi_d = mid - BOUND_W'(1);
    end else begin
      lo_d = mid + BOUND_W'(1);
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.sel_none = (sel_q == SEL_NONE);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.hit      = (probe_val == key_q);
  assign stat_o.last     = (lo_d > hi_d);

  assign found_o  = found_q;
  assign status_o = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_LOAD;
      sel_q    <= SEL_BRANCH;
      count_q  <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
    end else begin
      if (cmd_i.capture) begin
        op_q     <= op_e'(opcode_i);
        sel_q    <= sel_e'(field_select_i);
        found_q  <= 1'b0;
        status_q <= 1'b0;
      end
      if (cmd_i.load) begin
        if (full) begin
          status_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.init) begin
        lo_q <= '0;
        hi_q <= $signed({1'b0, count_q}) - BOUND_W'(1);
      end
      if (cmd_i.advance) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
      if (cmd_i.mark_found) begin
        found_q <= 1'b1;
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= (field_select_i == SEL_BRANCH) ? (branch_value_i & NAME_MASK)
             : {{(BRANCH_W - NUM_W){1'b0}}, number_key_i ^ SIGN_BIAS};
      wr_rec_q.branch <= branch_value_i & NAME_MASK;
      wr_rec_q.loan   <= loan_value_i;
      wr_rec_q.amount <= amount_value_i;
    end
  end

  // record memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      rec_mem_q[count_q[IDX_W-1:0]] <= wr_rec_q;
    end
    rd_q <= rec_mem_q[rd_addr];
  end

endmodule

[hdl/rts_checker.sv]
`include "assert_macros.svh"

module rts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic found_o,
  input logic status_o
);

  // an accepted transaction makes the block busy once the state register takes it
  `RTS_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accept did not raise busy")

  // a result only appears while a transaction is in flight
  `RTS_ASSERT(a_done_busy, done_o |-> busy_o, "result strobe while idle")

  // result strobe lasts a single cycle
  `RTS_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe held")

  // busy only drops right after a result was delivered
  `RTS_ASSERT(a_busy_end, $fell(busy_o) |-> $past(done_o), "busy dropped without result")

  // a search hit and a dropped load are never reported together
  `RTS_ASSERT_NEVER(a_flags_excl, done_o && found_o && status_o, "found and status both set")

endmodule

bind record_table_search_top rts_checker u_rts_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .found_o  (found_o),
  .status_o (status_o)
);

[verif/record_table_search_top_tb.sv]
`timescale 1ns / 100ps

module record_table_search_top_tb;
  import rts_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_ITEMS = 950;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    op_e         op;
    sel_e        sel;
    logic [63:0] branch;
    logic [31:0] loan;
    logic [31:0] amount;
    logic [31:0] key;
    logic        typed;
    logic        exp_found;
    logic        exp_status;
  } cmd_row_t;

  typedef struct packed {
    op_e  op;
    logic found;
    logic status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic done_o;
  logic [OP_W-1:0] opcode_i;
  logic [SEL_W-1:0] field_select_i;
  logic [BRANCH_W-1:0] branch_value_i;
  logic signed [NUM_W-1:0] loan_value_i;
  logic signed [NUM_W-1:0] amount_value_i;
  logic signed [NUM_W-1:0] number_key_i;
  logic found_o;
  logic status_o;

  record_table_search_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .opcode_i       (opcode_i),
    .field_select_i (field_select_i),
    .branch_value_i (branch_value_i),
    .loan_value_i   (loan_value_i),
    .amount_value_i (amount_value_i),
    .number_key_i   (number_key_i),
    .found_o        (found_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] tbl_branch [TABLE_DEPTH];
  logic [31:0] tbl_loan   [TABLE_DEPTH];
  logic [31:0] tbl_amount [TABLE_DEPTH];
  int          tbl_count;
  int          probe_lo;
  int          probe_hi;

  outcome_t outcome_q[$];
  cmd_row_t dir_rows[$];
  int       error_cnt;
  int       cycle_cnt;
  int       items_sent;
  int       burst_left;

  // episode scratch: record set, usually sorted, numbers kept as biased (unsigned-ordered) keys
  logic [63:0] ep_branch [TABLE_DEPTH];
  logic [31:0] ep_loan   [TABLE_DEPTH];
  logic [31:0] ep_amount [TABLE_DEPTH];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  // ordered key of table entry idx on the given field
  function automatic logic [63:0] entry_key(input int idx, input sel_e sel);
    case (sel)
      SEL_BRANCH: entry_key = tbl_branch[idx];
      SEL_LOAN:   entry_key = {32'd0, tbl_loan[idx] ^ SIGN_BIAS};
      default:    entry_key = {32'd0, tbl_amount[idx] ^ SIGN_BIAS};
    endcase
  endfunction

  function automatic outcome_t run_table_cmd(input cmd_row_t c);
    outcome_t    res;
    logic [63:0] key;
    logic [63:0] v;
    int          lo;
    int          hi;
    int          mid;
    res.op = c.op;
    res.found = 1'b0;
    res.status = 1'b0;
    key = (c.sel == SEL_BRANCH) ? (c.branch & NAME_MASK) : {32'd0, c.key ^ SIGN_BIAS};
    case (c.op)
      OP_LOAD: begin
        if (tbl_count < TABLE_DEPTH) begin
          tbl_branch[tbl_count] = c.branch & NAME_MASK;
          tbl_loan[tbl_count]   = c.loan;
          tbl_amount[tbl_count] = c.amount;
          tbl_count++;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_CLEAR: tbl_count = 0;
      OP_LINEAR: begin
        if (c.sel != SEL_NONE)
          for (int i = 0; i < tbl_count; i++)
            if (entry_key(i, c.sel) == key) res.found = 1'b1;
      end
      default: begin
        if (c.sel != SEL_NONE) begin
          lo = 0;
          hi = tbl_count - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            v = entry_key(mid, c.sel);
            if (v == key) begin
              res.found = 1'b1;
              break;
            end
            if (key < v) hi = mid - 1;
            else lo = mid + 1;
          end
          probe_lo = lo & 'h7f;
          probe_hi = hi & 'h7f;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one command transaction: optional idle gap, then hold start until accepted
  task automatic issue(input cmd_row_t c);
    int       gap;
    outcome_t pred;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i       <= c.op;
    field_select_i <= c.sel;
    branch_value_i <= c.branch;
    loan_value_i   <= c.loan;
    amount_value_i <= c.amount;
    number_key_i   <= c.key;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pred = run_table_cmd(c);
    if (c.typed) begin
      pred.found = c.exp_found;
      pred.status = c.exp_status;
    end
    outcome_q.push_back(pred);
    items_sent++;
  endtask

  task automatic add_row(input op_e op, input sel_e sel, input logic [63:0] br,
                         input logic [31:0] ln, input logic [31:0] am,
                         input logic [31:0] ky, input logic typed,
                         input logic f, input logic s);
    cmd_row_t r;
    r = '{op: op, sel: sel, branch: br, loan: ln, amount: am, key: ky,
          typed: typed, exp_found: f, exp_status: s};
    dir_rows.push_back(r);
  endtask

  function automatic cmd_row_t rand_row(input op_e op);
    cmd_row_t r;
    r.op = op;
    r.sel = sel_e'($urandom_range(0, 3));
    r.branch = {$urandom, $urandom};
    r.loan = $urandom;
    r.amount = $urandom;
    r.key = $urandom;
    r.typed = 1'b0;
    r.exp_found = 1'b0;
    r.exp_status = 1'b0;
    return r;
  endfunction

  // clear, load a record set (usually sorted on every field), then search it
  task automatic run_episode(input bit fill_up);
    cmd_row_t    r;
    int          n_load;
    int          n_tab;
    int          n_search;
    int          j;
    int          idx;
    int          pick;
    bit          sorted;
    bit          narrow;
    logic [63:0] vb;
    logic [31:0] vl;
    logic [31:0] va;
    logic [63:0] kv;
    n_load = fill_up ? TABLE_DEPTH + $urandom_range(1, 3)
           : ($urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(0, 12));
    n_tab = (n_load > TABLE_DEPTH) ? TABLE_DEPTH : n_load;
    sorted = ($urandom_range(0, 5) != 0);
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n_tab; i++) begin
      vb = {$urandom, $urandom};
      vl = $urandom;
      va = $urandom;
      if (narrow) begin
        // tight value spread so duplicates and near misses show up
        vb = vb[63] ? {60'hfffffffffffffff, vb[3:0]} : {60'd0, vb[3:0]};
        vl = {vl[31], 27'd0, vl[3:0]};
        va = {va[31], 27'd0, va[3:0]};
      end
      j = i;
      if (sorted) while (j > 0 && ep_branch[j-1] > vb) begin
        ep_branch[j] = ep_branch[j-1];
        j--;
      end
      ep_branch[j] = vb;
      j = i;
      if (sorted) while (j > 0 && ep_loan[j-1] > vl) begin
        ep_loan[j] = ep_loan[j-1];
        j--;
      end
      ep_loan[j] = vl;
      j = i;
      if (sorted) while (j > 0 && ep_amount[j-1] > va) begin
        ep_amount[j] = ep_amount[j-1];
        j--;
      end
      ep_amount[j] = va;
    end

    issue(rand_row(OP_CLEAR));
    for (int i = 0; i < n_load; i++) begin
      r = rand_row(OP_LOAD);
      if (i < n_tab) begin
        r.branch = ep_branch[i];
        r.loan = ep_loan[i] ^ SIGN_BIAS;
        r.amount = ep_amount[i] ^ SIGN_BIAS;
      end
      issue(r);
    end

    n_search = $urandom_range(4, 20);
    for (int i = 0; i < n_search; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        issue(rand_row(OP_LOAD));
        continue;
      end
      r = rand_row($urandom_range(0, 1) ? OP_LINEAR : OP_BINARY);
      r.sel = sel_e'(($urandom_range(0, 14) == 0) ? SEL_NONE : $urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (n_tab > 0 && pick < 75) begin
        idx = $urandom_range(0, n_tab - 1);
        case (r.sel)
          SEL_BRANCH: kv = ep_branch[idx];
          SEL_LOAN:   kv = {32'd0, ep_loan[idx]};
          default:    kv = {32'd0, ep_amount[idx]};
        endcase
        if (pick >= 50) kv = $urandom_range(0, 1) ? kv + 64'd1 : kv - 64'd1;
        if (r.sel == SEL_BRANCH) r.branch = kv;
        else r.key = kv[31:0] ^ SIGN_BIAS;
      end
      issue(r);
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t exp_out;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result strobe with no transaction pending");
      end else begin
        exp_out = outcome_q.pop_front();
        if (found_o !== exp_out.found)
          report_mismatch($sformatf("%s: found %b, expected %b",
                                    exp_out.op.name(), found_o, exp_out.found));
        if (status_o !== exp_out.status)
          report_mismatch($sformatf("%s: status %b, expected %b",
                                    exp_out.op.name(), status_o, exp_out.status));
      end
    end
  end

  // cycle_cnt starts at zero as an int and is only written here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("record_table_search_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n_episode;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    opcode_i       <= OP_CLEAR;
    field_select_i <= SEL_BRANCH;
    branch_value_i <= '0;
    loan_value_i   <= '0;
    amount_value_i <= '0;
    number_key_i   <= '0;
    error_cnt = 0;
    items_sent = 0;
    burst_left = 0;
    tbl_count = 0;
    probe_lo = 0;
    probe_hi = 0;
    n_episode = 0;

    // searches on the empty table
    add_row(OP_LINEAR, SEL_BRANCH, 64'd0, 32'd0, 32'd0, 32'd0, 1, 0, 0);
    add_row(OP_BINARY, SEL_LOAN, 64'd0, 32'd0, 32'd0, 32'd0, 1, 0, 0);
    add_row(OP_LINEAR, SEL_AMOUNT, 64'd0, 32'd0, 32'd0, 32'h8000_0000, 1, 0, 0);
    // three records, sorted on every field, spanning the extremes
    add_row(OP_LOAD, SEL_BRANCH, 64'd0, 32'h8000_0000, 32'h8000_0000, 32'd0, 1, 0, 0);
    add_row(OP_LOAD, SEL_LOAN, 64'h4142_4300_0000_0000, 32'hffff_ffff, 32'd0, 32'd0,
            0, 0, 0);
    add_row(OP_LOAD, SEL_AMOUNT, 64'hffff_ffff_ffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'hffff_ffff, 0, 0, 0);
    add_row(OP_LINEAR, SEL_BRANCH, 64'h4142_4300_0000_0000, 32'd0, 32'd0, 32'd0, 0, 0, 0);
    add_row(OP_LINEAR, SEL_LOAN, 64'd0, 32'd0, 32'd0, 32'hffff_ffff, 0, 0, 0);
    add_row(OP_LINEAR, SEL_AMOUNT, 64'd0, 32'd0, 32'd0, 32'h7fff_ffff, 0, 0, 0);
    add_row(OP_LINEAR, SEL_AMOUNT, 64'd0, 32'd0, 32'd0, 32'd5, 0, 0, 0);
    add_row(OP_BINARY, SEL_BRANCH, 64'hffff_ffff_ffff_ffff, 32'd0, 32'd0, 32'd0, 0, 0, 0);
    add_row(OP_BINARY, SEL_BRANCH, 64'd0, 32'd0, 32'd0, 32'd0, 0, 0, 0);
    add_row(OP_BINARY, SEL_LOAN, 64'd0, 32'd0, 32'd0, 32'h8000_0000, 0, 0, 0);
    add_row(OP_BINARY, SEL_AMOUNT, 64'd0, 32'd0, 32'd0, 32'd0, 0, 0, 0);
    add_row(OP_BINARY, SEL_LOAN, 64'd0, 32'd0, 32'd0, 32'd1, 0, 0, 0);
    // unused selector never matches, even with keys that are in the table
    add_row(OP_LINEAR, SEL_NONE, 64'd0, 32'd0, 32'd0, 32'h8000_0000, 1, 0, 0);
    add_row(OP_BINARY, SEL_NONE, 64'hffff_ffff_ffff_ffff, 32'd0, 32'd0, 32'd0, 1, 0, 0);
    // clear, then the old records must be gone
    add_row(OP_CLEAR, SEL_BRANCH, 64'd0, 32'd0, 32'd0, 32'd0, 1, 0, 0);
    add_row(OP_LINEAR, SEL_LOAN, 64'd0, 32'd0, 32'd0, 32'hffff_ffff, 1, 0, 0);
    add_row(OP_BINARY, SEL_BRANCH, 64'hffff_ffff_ffff_ffff, 32'd0, 32'd0, 32'd0, 1, 0, 0);
    add_row(OP_LOAD, SEL_NONE, 64'h8000_0000_0000_0001, 32'h7fff_ffff, 32'hffff_ffff,
            32'd0, 0, 0, 0);
    add_row(OP_BINARY, SEL_AMOUNT, 64'd0, 32'd0, 32'd0, 32'hffff_ffff, 0, 0, 0);
    add_row(OP_LINEAR, SEL_BRANCH, 64'h8000_0000_0000_0001, 32'd0, 32'd0, 32'd0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i]);

    // every sixth set fills the table and overflows it
    while (items_sent < TARGET_ITEMS) begin
      run_episode(n_episode % 6 == 1);
      n_episode++;
    end

    @(posedge clk_i);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("record_table_search_top_tb OK");
    end else begin
      $display("record_table_search_top_tb NOT OK");
    end
    $finish;
  end

endmodule
